// ===== rtl/krt_pkg.sv =====
// Package for the sorted keyed record table.
// Holds the action and status codes, record and command types, and cell control.
// No dependencies.
package krt_pkg;

  localparam int unsigned CapacityDef = 64;
  localparam int unsigned ActW = 3;
  localparam int unsigned StatW = 3;

  localparam logic [ActW-1:0] ACT_INSERT = 3'd0;
  localparam logic [ActW-1:0] ACT_LOOKUP = 3'd1;
  localparam logic [ActW-1:0] ACT_MODIFY = 3'd2;
  localparam logic [ActW-1:0] ACT_DELETE = 3'd3;
  localparam logic [ActW-1:0] ACT_LIST   = 3'd4;

  localparam logic [StatW-1:0] ST_OK       = 3'd0;
  localparam logic [StatW-1:0] ST_DUP      = 3'd1;
  localparam logic [StatW-1:0] ST_NOTFOUND = 3'd2;
  localparam logic [StatW-1:0] ST_FULL     = 3'd3;
  localparam logic [StatW-1:0] ST_EMPTY    = 3'd4;

  typedef struct packed {
    logic signed [31:0] key;
    logic signed [31:0] price;
    logic [63:0]        tag;
  } rec_t;

  typedef struct packed {
    logic [ActW-1:0] action;
    rec_t            rec;
  } cmd_t;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_DELETE,
    CELL_MODIFY,
    CELL_ROTATE
  } cell_op_e;

  typedef struct packed {
    cell_op_e op;
    rec_t     rec;
  } cell_ctrl_t;

endpackage

// ===== rtl/krt_if.sv =====
// Handshake channels of the sorted keyed record table.
// Command and response interfaces with source and sink modports; uses krt_pkg.
interface krt_cmd_if import krt_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [ActW-1:0]    action;
  logic signed [31:0] key;
  logic signed [31:0] price;
  logic [63:0]        name_tag;

  modport source (output valid, action, key, price, name_tag, input ready);
  modport sink   (input valid, action, key, price, name_tag, output ready);
endinterface

interface krt_rsp_if import krt_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [StatW-1:0]   status;
  logic signed [31:0] out_key;
  logic signed [31:0] out_price;
  logic [63:0]        out_name_tag;
  logic               last;

  modport source (output valid, status, out_key, out_price, out_name_tag, last,
                  input ready);
  modport sink   (input valid, status, out_key, out_price, out_name_tag, last,
                  output ready);
endinterface

// ===== rtl/keyed_record_table_sorted_dump.sv =====
// Sorted keyed record table: top level with command sequencer and cell chain.
// Depends on krt_pkg, krt_if and krt_cell.
//
// Usage:
//   cmd_i carries one command word (action, key, price, name_tag); rsp_o returns
//   response words (status, out_key, out_price, out_name_tag, last).
//   Insert, lookup, modify and delete each give one word; list gives one word
//   per stored record in ascending signed key order, or one empty word.
//   A command is taken only while the sequencer is idle. In the cycle after the
//   accept, every cell compares its key to the command key in parallel, and the
//   single response word of a short command is loaded into the output register
//   in that cycle, unless a stalled receiver still holds the previous word there.
//   List streams one record per cycle while the receiver takes each word, by
//   rotating the valid part of the chain once around, which leaves the order
//   unchanged.
//   Reset clears the record count and the handshake state; stored records are
//   not cleared and no clearing pass is needed. A stalled receiver holds the
//   output register and freezes the sequencer, with no word lost.
//   Unused action codes give no response and change nothing.
module keyed_record_table_sorted_dump import krt_pkg::*; #(
  parameter int unsigned Capacity = CapacityDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  krt_cmd_if.sink   cmd_i,
  krt_rsp_if.source rsp_o
);

  localparam int unsigned CntW = $clog2(Capacity + 1);
  localparam logic [CntW-1:0] CapC = CntW'(Capacity);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_LIST = 2'd2;

  logic [1:0]      state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] remain_q, remain_d;
  cmd_t            cmd_q;

  logic            rsp_valid_q, rsp_valid_d;
  logic [StatW-1:0] rsp_status_q;
  rec_t            rsp_rec_q;
  logic            rsp_last_q;

  logic             emit;
  logic [StatW-1:0] e_status;
  rec_t             e_rec;
  logic             e_last;

  cell_ctrl_t       ctrl;
  rec_t             recs [Capacity];
  logic [Capacity-1:0] lt, eq;
  rec_t             hit_rec;
  logic             any_eq;
  logic             slot_free;

  assign cmd_i.ready = (state_q == S_IDLE);
  assign slot_free   = !rsp_valid_q || rsp_o.ready;
  assign any_eq      = |eq;

  always_comb begin
    hit_rec = '0;
    for (int i = 0; i < Capacity; i++) begin
      if (eq[i]) hit_rec = hit_rec | recs[i];
    end
  end

  for (genvar g = 0; g < Capacity; g++) begin : g_cell
    rec_t left, right;
    logic left_lt;
    if (g == 0) begin : g_first
      assign left    = '0;
      assign left_lt = 1'b1;
    end else begin : g_mid
      assign left    = recs[g-1];
      assign left_lt = lt[g-1];
    end
    if (g == Capacity - 1) begin : g_end
      assign right = recs[g];
    end else begin : g_inner
      assign right = recs[g+1];
    end
    krt_cell #(.Idx(g), .CntW(CntW)) u_cell (
      .clk_i     (clk_i),
      .ctrl_i    (ctrl),
      .count_i   (count_q),
      .left_i    (left),
      .left_lt_i (left_lt),
      .right_i   (right),
      .head_i    (recs[0]),
      .rec_o     (recs[g]),
      .lt_o      (lt[g]),
      .eq_o      (eq[g])
    );
  end

  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    remain_d = remain_q;
    ctrl.op  = CELL_HOLD;
    ctrl.rec = cmd_q.rec;
    emit     = 1'b0;
    e_status = ST_OK;
    e_rec    = '0;
    e_last   = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        if (cmd_i.valid) state_d = S_EXEC;
      end
      S_EXEC: begin
        if (slot_free) begin
          state_d = S_IDLE;
          unique case (cmd_q.action)
            ACT_INSERT: begin
              emit = 1'b1;
              if (any_eq) begin
                e_status = ST_DUP;
                e_rec    = hit_rec;
              end else if (count_q == CapC) begin
                e_status = ST_FULL;
              end else begin
                e_rec   = cmd_q.rec;
                ctrl.op = CELL_INSERT;
                count_d = count_q + 1'b1;
              end
            end
            ACT_LOOKUP, ACT_MODIFY, ACT_DELETE: begin
              emit = 1'b1;
              if (!any_eq) begin
                e_status = ST_NOTFOUND;
              end else if (cmd_q.action == ACT_MODIFY) begin
                e_rec       = cmd_q.rec;
                e_rec.key   = hit_rec.key;
                ctrl.op     = CELL_MODIFY;
              end else if (cmd_q.action == ACT_DELETE) begin
                e_rec   = hit_rec;
                ctrl.op = CELL_DELETE;
                count_d = count_q - 1'b1;
              end else begin
                e_rec = hit_rec;
              end
            end
            ACT_LIST: begin
              emit = 1'b1;
              if (count_q == '0) begin
                e_status = ST_EMPTY;
              end else begin
                e_rec    = recs[0];
                ctrl.op  = CELL_ROTATE;
                e_last   = (count_q == CntW'(1));
                remain_d = count_q - 1'b1;
                if (!e_last) state_d = S_LIST;
              end
            end
            default: emit = 1'b0;
          endcase
        end
      end
      S_LIST: begin
        if (slot_free) begin
          emit     = 1'b1;
          e_rec    = recs[0];
          ctrl.op  = CELL_ROTATE;
          e_last   = (remain_q == CntW'(1));
          remain_d = remain_q - 1'b1;
          if (e_last) state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    rsp_valid_d = rsp_valid_q && !rsp_o.ready;
    if (emit) rsp_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      remain_q    <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      remain_q    <= remain_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.valid && cmd_i.ready) begin
      cmd_q.action    <= cmd_i.action;
      cmd_q.rec.key   <= cmd_i.key;
      cmd_q.rec.price <= cmd_i.price;
      cmd_q.rec.tag   <= cmd_i.name_tag;
    end
    if (emit) begin
      rsp_status_q <= e_status;
      rsp_rec_q    <= e_rec;
      rsp_last_q   <= e_last;
    end
  end

  assign rsp_o.valid        = rsp_valid_q;
  assign rsp_o.status       = rsp_status_q;
  assign rsp_o.out_key      = rsp_rec_q.key;
  assign rsp_o.out_price    = rsp_rec_q.price;
  assign rsp_o.out_name_tag = rsp_rec_q.tag;
  assign rsp_o.last         = rsp_last_q;

endmodule

// ===== rtl/krt_cell.sv =====
// One slot of the record chain: holds a record, compares its key to the command key.
// Shifts toward either neighbor, updates in place or rotates; uses krt_pkg.
module krt_cell import krt_pkg::*; #(
  parameter int unsigned Idx  = 0,
  parameter int unsigned CntW = 7
) (
  input  logic            clk_i,
  input  cell_ctrl_t      ctrl_i,
  input  logic [CntW-1:0] count_i,
  input  rec_t            left_i,
  input  logic            left_lt_i,
  input  rec_t            right_i,
  input  rec_t            head_i,
  output rec_t            rec_o,
  output logic            lt_o,
  output logic            eq_o
);

  localparam logic [CntW-1:0] IdxC  = CntW'(Idx);
  localparam logic [CntW:0]   IdxP1 = (CntW+1)'(Idx + 1);

  rec_t rec_q, rec_d;
  logic valid;

  assign valid = IdxC < count_i;
  assign lt_o  = valid && (rec_q.key < ctrl_i.rec.key);
  assign eq_o  = valid && (rec_q.key == ctrl_i.rec.key);
  assign rec_o = rec_q;

  always_comb begin
    rec_d = rec_q;
    unique case (ctrl_i.op)
      CELL_INSERT: begin
        if (!lt_o) begin
          rec_d = left_lt_i ? ctrl_i.rec : left_i;
        end
      end
      CELL_DELETE: begin
        if (!lt_o) rec_d = right_i;
      end
      CELL_MODIFY: begin
        if (eq_o) begin
          rec_d.price = ctrl_i.rec.price;
          rec_d.tag   = ctrl_i.rec.tag;
        end
      end
      CELL_ROTATE: begin
        if (IdxP1 < {1'b0, count_i}) rec_d = right_i;
        else if (IdxP1 == {1'b0, count_i}) rec_d = head_i;
      end
      default: rec_d = rec_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    rec_q <= rec_d;
  end

endmodule

// ===== rtl/krt_checker.sv =====
// Port-level checks for the sorted keyed record table, bound to the top level.
// Depends on krt_pkg and keyed_record_table_sorted_dump.
module krt_checker import krt_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             cmd_valid_i,
  input logic             cmd_ready_i,
  input logic             rsp_valid_i,
  input logic             rsp_ready_i,
  input logic [StatW-1:0] rsp_status_i,
  input logic [31:0]      rsp_key_i,
  input logic [31:0]      rsp_price_i,
  input logic [63:0]      rsp_tag_i,
  input logic             rsp_last_i
);

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_status_i) &&
    $stable(rsp_key_i) && $stable(rsp_last_i))
    else $error("response word changed while stalled");

  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_valid_i && cmd_ready_i |=> !cmd_ready_i)
    else $error("second command taken before first was executed");

  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_status_i != ST_OK |-> rsp_last_i)
    else $error("error status without last");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (rsp_status_i == ST_FULL || rsp_status_i == ST_NOTFOUND ||
    rsp_status_i == ST_EMPTY) |-> rsp_key_i == '0 && rsp_price_i == '0 &&
    rsp_tag_i == '0)
    else $error("error response carries record data");

endmodule

bind keyed_record_table_sorted_dump krt_checker u_krt_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .cmd_valid_i  (cmd_i.valid),
  .cmd_ready_i  (cmd_i.ready),
  .rsp_valid_i  (rsp_o.valid),
  .rsp_ready_i  (rsp_o.ready),
  .rsp_status_i (rsp_o.status),
  .rsp_key_i    (rsp_o.out_key),
  .rsp_price_i  (rsp_o.out_price),
  .rsp_tag_i    (rsp_o.out_name_tag),
  .rsp_last_i   (rsp_o.last)
);

// ===== test/testbench.sv =====
// Testbench for keyed_record_table_sorted_dump: a directed command table, then random
// commands, each response word checked against a sorted-table predictor in this file.
// Depends on krt_pkg and the krt_cmd_if / krt_rsp_if interfaces.
module testbench;
  import krt_pkg::*;

  localparam int unsigned Capacity = CapacityDef;
  localparam int PoolSize = 16;
  localparam int HoldCycles = 300;
  localparam int DrainCycles = 2 * Capacity + 8;
  localparam int CycleLimit = 4_000_000;
  localparam int MaxReported = 10;

  localparam logic signed [31:0] KeyMin = 32'sh8000_0000;
  localparam logic signed [31:0] KeyMax = 32'sh7fff_ffff;

  localparam logic [ActW-1:0] ACT_SPARE0 = 3'd5;
  localparam logic [ActW-1:0] ACT_SPARE1 = 3'd6;
  localparam logic [ActW-1:0] ACT_SPARE2 = 3'd7;

  typedef struct packed {
    logic [StatW-1:0] status;
    rec_t             rec;
    logic             last;
  } rsp_word_t;

  typedef struct packed {
    cmd_t      cmd;
    bit        fixed;
    rsp_word_t want;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  krt_cmd_if cmd_if ();
  krt_rsp_if rsp_if ();

  keyed_record_table_sorted_dump #(
    .Capacity(Capacity)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (cmd_if),
    .rsp_o (rsp_if)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  rec_t      shadow_recs[Capacity];
  int        shadow_count = 0;
  rsp_word_t step_words[Capacity];
  rsp_word_t pending_words[$];
  logic signed [31:0] key_pool[PoolSize];

  int mismatches = 0;
  int words_checked = 0;
  int cmds_taken = 0;
  int list_cmds = 0;
  int full_hits = 0;
  int peak_count = 0;
  bit hold_done = 1'b0;
  bit cmd_steady = 1'b0;

  function automatic rec_t mk_rec(input logic signed [31:0] key, price,
                                  input logic [63:0] tag);
    rec_t r;
    r.key = key;
    r.price = price;
    r.tag = tag;
    return r;
  endfunction

  function automatic dir_row_t dcmd(input logic [ActW-1:0] act,
                                    input logic signed [31:0] key, price,
                                    input logic [63:0] tag);
    dir_row_t d;
    d = '0;
    d.cmd.action = act;
    d.cmd.rec = mk_rec(key, price, tag);
    return d;
  endfunction

  function automatic dir_row_t dchk(input logic [ActW-1:0] act,
                                    input logic signed [31:0] key, price,
                                    input logic [63:0] tag,
                                    input logic [StatW-1:0] st, input rec_t rec);
    dir_row_t d;
    d = dcmd(act, key, price, tag);
    d.fixed = 1'b1;
    d.want.status = st;
    d.want.rec = rec;
    d.want.last = 1'b1;
    return d;
  endfunction

  // Apply one command to the sorted shadow table; fill step_words, return the count.
  function automatic int table_step(input cmd_t c);
    int pos;
    int n;
    bit hit;
    pos = 0;
    while (pos < shadow_count && $signed(shadow_recs[pos].key) < $signed(c.rec.key))
      pos++;
    hit = (pos < shadow_count) && (shadow_recs[pos].key == c.rec.key);
    n = 1;
    step_words[0].status = ST_OK;
    step_words[0].rec = '0;
    step_words[0].last = 1'b1;
    case (c.action)
      ACT_INSERT: begin
        if (hit) begin
          step_words[0].status = ST_DUP;
          step_words[0].rec = shadow_recs[pos];
        end else if (shadow_count >= Capacity) begin
          step_words[0].status = ST_FULL;
        end else begin
          for (int i = shadow_count; i > pos; i--) shadow_recs[i] = shadow_recs[i-1];
          shadow_recs[pos] = c.rec;
          shadow_count++;
          step_words[0].rec = c.rec;
        end
      end
      ACT_LOOKUP, ACT_MODIFY, ACT_DELETE: begin
        if (!hit) begin
          step_words[0].status = ST_NOTFOUND;
        end else begin
          if (c.action == ACT_MODIFY) begin
            shadow_recs[pos].price = c.rec.price;
            shadow_recs[pos].tag = c.rec.tag;
          end
          step_words[0].rec = shadow_recs[pos];
          if (c.action == ACT_DELETE) begin
            for (int i = pos; i + 1 < shadow_count; i++) shadow_recs[i] = shadow_recs[i+1];
            shadow_count--;
          end
        end
      end
      ACT_LIST: begin
        if (shadow_count == 0) begin
          step_words[0].status = ST_EMPTY;
        end else begin
          for (int i = 0; i < shadow_count; i++) begin
            step_words[i].status = ST_OK;
            step_words[i].rec = shadow_recs[i];
            step_words[i].last = (i == shadow_count - 1);
          end
          n = shadow_count;
        end
      end
      default: n = 0;
    endcase
    return n;
  endfunction

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic cmd_t rand_cmd(input bit use_stored);
    cmd_t c;
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) c.action = ACT_INSERT;
    else if (r < 45) c.action = ACT_LOOKUP;
    else if (r < 60) c.action = ACT_MODIFY;
    else if (r < 85) c.action = ACT_DELETE;
    else if (r < 93) c.action = ACT_LIST;
    else c.action = ACT_SPARE0 + 3'($urandom_range(0, 2));
    r = $urandom_range(0, 99);
    if (use_stored && shadow_count > 0 && r < 60)
      c.rec.key = shadow_recs[$urandom_range(0, shadow_count - 1)].key;
    else if (r < 90)
      c.rec.key = key_pool[$urandom_range(0, PoolSize - 1)];
    else
      c.rec.key = $urandom;
    c.rec.price = $urandom;
    c.rec.tag = {$urandom, $urandom};
    return c;
  endfunction

  task automatic send_cmd(input cmd_t c, input bit fixed, input rsp_word_t want);
    int gap;
    int n;
    if (cmds_taken % 32 == 0) cmd_steady = ($urandom_range(0, 2) == 0);
    gap = cmd_steady ? 0 : idle_len();
    if (gap > 0) begin
      cmd_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    cmd_if.valid <= 1'b1;
    cmd_if.action <= c.action;
    cmd_if.key <= c.rec.key;
    cmd_if.price <= c.rec.price;
    cmd_if.name_tag <= c.rec.tag;
    do @(posedge clk_i); while (!cmd_if.ready);
    cmds_taken++;
    n = table_step(c);
    if (c.action == ACT_LIST) list_cmds++;
    if (n == 1 && step_words[0].status == ST_FULL) full_hits++;
    if (shadow_count > peak_count) peak_count = shadow_count;
    if (fixed && n == 1) pending_words.push_back(want);
    else for (int i = 0; i < n; i++) pending_words.push_back(step_words[i]);
  endtask

  task automatic check_word();
    rsp_word_t want;
    if (pending_words.size() == 0) begin
      mismatches++;
      if (mismatches <= MaxReported)
        $display("unexpected word: status %0d key %0d price %0d tag %h last %0b",
                 rsp_if.status, rsp_if.out_key, rsp_if.out_price, rsp_if.out_name_tag,
                 rsp_if.last);
      return;
    end
    want = pending_words.pop_front();
    words_checked++;
    if (rsp_if.status !== want.status || rsp_if.out_key !== want.rec.key ||
        rsp_if.out_price !== want.rec.price || rsp_if.out_name_tag !== want.rec.tag ||
        rsp_if.last !== want.last) begin
      mismatches++;
      if (mismatches <= MaxReported) begin
        $display("mismatch on word %0d: expected status %0d key %0d price %0d tag %h last %0b",
                 words_checked, want.status, want.rec.key, want.rec.price, want.rec.tag,
                 want.last);
        $display("                      got status %0d key %0d price %0d tag %h last %0b",
                 rsp_if.status, rsp_if.out_key, rsp_if.out_price, rsp_if.out_name_tag,
                 rsp_if.last);
      end
    end
  endtask

  initial begin : response_side
    int stall_left;
    int cyc;
    bit steady;
    stall_left = 0;
    cyc = 0;
    steady = 1'b0;
    rsp_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (rsp_if.valid && rsp_if.ready) check_word();
      cyc++;
      if (cyc % 64 == 0) steady = ($urandom_range(0, 3) == 0);
      // hold off long enough to back up the command side
      if (!hold_done && cmds_taken >= 60) begin
        hold_done = 1'b1;
        rsp_if.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        stall_left = 0;
      end
      if (stall_left == 0 && !steady && $urandom_range(0, 3) == 0) stall_left = idle_len();
      if (stall_left > 0) begin
        stall_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("timeout after %0d cycles, %0d words still expected", cycles,
             pending_words.size());
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin : stimulus
    dir_row_t directed[$];
    cmd_t c;
    cmd_if.valid = 1'b0;
    cmd_if.action = ACT_INSERT;
    cmd_if.key = '0;
    cmd_if.price = '0;
    cmd_if.name_tag = '0;
    key_pool[0] = KeyMin;
    key_pool[1] = KeyMax;
    key_pool[2] = 0;
    key_pool[3] = -1;
    key_pool[4] = 1;
    for (int i = 5; i < PoolSize; i++) key_pool[i] = $urandom;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    directed = '{
      dchk(ACT_LIST, 0, 0, 0, ST_EMPTY, '0),
      dchk(ACT_LOOKUP, 5, 0, 0, ST_NOTFOUND, '0),
      dchk(ACT_DELETE, KeyMin, 0, 0, ST_NOTFOUND, '0),
      dchk(ACT_MODIFY, -1, 7, '1, ST_NOTFOUND, '0),
      dchk(ACT_INSERT, KeyMax, KeyMin, '1, ST_OK, mk_rec(KeyMax, KeyMin, '1)),
      dchk(ACT_INSERT, KeyMin, KeyMax, '0, ST_OK, mk_rec(KeyMin, KeyMax, '0)),
      dchk(ACT_INSERT, 0, 0, 64'h0123_4567_89ab_cdef, ST_OK,
           mk_rec(0, 0, 64'h0123_4567_89ab_cdef)),
      dchk(ACT_INSERT, -1, -1, 64'haaaa_aaaa_aaaa_aaaa, ST_OK,
           mk_rec(-1, -1, 64'haaaa_aaaa_aaaa_aaaa)),
      dchk(ACT_INSERT, KeyMax, 99, 64'h5555_5555_5555_5555, ST_DUP,
           mk_rec(KeyMax, KeyMin, '1)),
      dcmd(ACT_LIST, '1, '1, '1),
      dchk(ACT_LOOKUP, 0, 12, 34, ST_OK, mk_rec(0, 0, 64'h0123_4567_89ab_cdef)),
      dcmd(ACT_MODIFY, -1, 32'sh1234_5678, 64'h5555_5555_5555_5555),
      dcmd(ACT_LOOKUP, -1, 0, 0),
      dcmd(ACT_DELETE, KeyMin, 0, 0),
      dcmd(ACT_SPARE0, '1, '1, '1),
      dcmd(ACT_SPARE1, 0, 0, 0),
      dcmd(ACT_SPARE2, KeyMax, KeyMin, 64'hdead_beef_0000_ffff),
      dcmd(ACT_LIST, 0, 0, 0),
      dcmd(ACT_DELETE, KeyMax, 0, 0),
      dcmd(ACT_DELETE, 0, 0, 0),
      dchk(ACT_DELETE, 0, 0, 0, ST_NOTFOUND, '0),
      dcmd(ACT_DELETE, -1, 0, 0),
      dchk(ACT_LIST, 0, 0, 0, ST_EMPTY, '0)
    };
    foreach (directed[i]) send_cmd(directed[i].cmd, directed[i].fixed, directed[i].want);

    // small key pool: plenty of hits, duplicates and misses
    repeat (110) send_cmd(rand_cmd(1'b0), 1'b0, '0);

    // fill to capacity, then a duplicate, an overflow and a full listing
    while (shadow_count < Capacity) begin
      c.action = ACT_INSERT;
      c.rec = mk_rec($urandom, $urandom, {$urandom, $urandom});
      send_cmd(c, 1'b0, '0);
    end
    c.rec.key = shadow_recs[$urandom_range(0, Capacity - 1)].key;
    send_cmd(c, 1'b0, '0);
    c.rec = mk_rec($urandom, $urandom, {$urandom, $urandom});
    send_cmd(c, 1'b0, '0);
    c.action = ACT_LIST;
    send_cmd(c, 1'b0, '0);

    repeat (120) send_cmd(rand_cmd(1'b1), 1'b0, '0);
    c.action = ACT_LIST;
    send_cmd(c, 1'b0, '0);
    cmd_if.valid <= 1'b0;

    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("covered %0d commands: %0d lists, %0d inserts into a full table, peak %0d records",
             cmds_taken, list_cmds, full_hits, peak_count);
    $display("checked %0d response words, %0d mismatches", words_checked, mismatches);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
